FILE: rtl/sfp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_pkg
// Types, constants and decode tables shared by the sensor feedback frame
// parser: request and response payloads, subpayload kinds and field maps.
// ----------------------------------------------------------------------------
package sfp_pkg;

   localparam int unsigned SFP_QUEUE_DEPTH = 2;

   // request and response payloads
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic        is_status;
      logic [5:0]  field_code;
      logic [5:0]  sample_index;
      logic [31:0] field_value;
      logic [3:0]  frame_status;
   } rsp_type;

   // subpayload kinds
   typedef enum logic [3:0] {
      KIND_BASIC     = 4'd0,
      KIND_IR        = 4'd1,
      KIND_GYRO      = 4'd2,
      KIND_CLIFF     = 4'd3,
      KIND_CURRENT   = 4'd4,
      KIND_HW_VER    = 4'd5,
      KIND_FW_VER    = 4'd6,
      KIND_RAW_GYRO  = 4'd7,
      KIND_GPIO      = 4'd8,
      KIND_UNIQUE_ID = 4'd9,
      KIND_UNKNOWN   = 4'd15
   } kind_type;

   // parser phases
   typedef enum logic [2:0] {
      PH_IDLE = 3'd0,
      PH_ID   = 3'd1,
      PH_LEN  = 3'd2,
      PH_BODY = 3'd3,
      PH_SKIP = 3'd4,
      PH_DEAD = 3'd5
   } phase_type;

   // classified byte as it sits in the queue
   typedef struct packed {
      logic [7:0] frame_byte;
      logic       frame_start;
      kind_type   kind;
      logic [6:0] third;
   } entry_type;

   typedef struct packed {
      logic      push;
      entry_type entry;
   } qwrite_type;

   // field position of one body byte
   typedef struct packed {
      logic       hit;
      logic [3:0] field;
      logic [1:0] pos;
      logic       last;
   } locate_type;

   // subpayload ids
   localparam logic [7:0] ID_BASIC     = 8'h01;
   localparam logic [7:0] ID_IR        = 8'h03;
   localparam logic [7:0] ID_GYRO      = 8'h04;
   localparam logic [7:0] ID_CLIFF     = 8'h05;
   localparam logic [7:0] ID_CURRENT   = 8'h06;
   localparam logic [7:0] ID_HW_VER    = 8'h0A;
   localparam logic [7:0] ID_FW_VER    = 8'h0B;
   localparam logic [7:0] ID_RAW_GYRO  = 8'h0D;
   localparam logic [7:0] ID_GPIO      = 8'h10;
   localparam logic [7:0] ID_UNIQUE_ID = 8'h13;

   // frame status codes
   localparam logic [3:0] STATUS_OK           = 4'd0;
   localparam logic [3:0] STATUS_BAD_CHECKSUM = 4'd1;
   localparam logic [3:0] ERR_BASIC           = 4'd2;
   localparam logic [3:0] ERR_IR              = 4'd3;
   localparam logic [3:0] ERR_GYRO            = 4'd4;
   localparam logic [3:0] ERR_CLIFF           = 4'd5;
   localparam logic [3:0] ERR_CURRENT         = 4'd6;
   localparam logic [3:0] ERR_HW_VER          = 4'd7;
   localparam logic [3:0] ERR_FW_VER          = 4'd8;
   localparam logic [3:0] ERR_RAW_GYRO        = 4'd9;
   localparam logic [3:0] ERR_GPIO            = 4'd10;
   localparam logic [3:0] ERR_UNIQUE_ID       = 4'd11;

   // field codes
   localparam logic [5:0] CODE_TIMESTAMP      = 6'd0;
   localparam logic [5:0] CODE_BUMPER         = 6'd1;
   localparam logic [5:0] CODE_CLIFF_BITS     = 6'd3;
   localparam logic [5:0] CODE_IR             = 6'd12;
   localparam logic [5:0] CODE_GYRO           = 6'd15;
   localparam logic [5:0] CODE_CLIFF_SENSOR   = 6'd17;
   localparam logic [5:0] CODE_CURRENT        = 6'd20;
   localparam logic [5:0] CODE_HW_VER         = 6'd22;
   localparam logic [5:0] CODE_FW_VER         = 6'd25;
   localparam logic [5:0] CODE_RAW_GYRO_FRAME = 6'd28;
   localparam logic [5:0] CODE_RAW_GYRO_X     = 6'd29;
   localparam logic [5:0] CODE_GPIO           = 6'd32;
   localparam logic [5:0] CODE_UNIQUE_ID      = 6'd37;

   localparam logic [2:0] FLAG_MASK = 3'h7;

   function automatic kind_type sfp_kind_of(logic [7:0] id);
      kind_type k;
      unique case (id)
         ID_BASIC:     k = KIND_BASIC;
         ID_IR:        k = KIND_IR;
         ID_GYRO:      k = KIND_GYRO;
         ID_CLIFF:     k = KIND_CLIFF;
         ID_CURRENT:   k = KIND_CURRENT;
         ID_HW_VER:    k = KIND_HW_VER;
         ID_FW_VER:    k = KIND_FW_VER;
         ID_RAW_GYRO:  k = KIND_RAW_GYRO;
         ID_GPIO:      k = KIND_GPIO;
         ID_UNIQUE_ID: k = KIND_UNIQUE_ID;
         default:      k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

   // fixed body length of each known kind other than raw gyro
   function automatic logic [4:0] sfp_kind_len(kind_type k);
      logic [4:0] len;
      unique case (k)
         KIND_BASIC:     len = 5'd15;
         KIND_IR:        len = 5'd3;
         KIND_GYRO:      len = 5'd7;
         KIND_CLIFF:     len = 5'd6;
         KIND_CURRENT:   len = 5'd2;
         KIND_HW_VER:    len = 5'd4;
         KIND_FW_VER:    len = 5'd4;
         KIND_GPIO:      len = 5'd16;
         KIND_UNIQUE_ID: len = 5'd12;
         default:        len = 5'd0;
      endcase
      return len;
   endfunction

   function automatic logic [3:0] sfp_kind_err(kind_type k);
      logic [3:0] err;
      unique case (k)
         KIND_BASIC:     err = ERR_BASIC;
         KIND_IR:        err = ERR_IR;
         KIND_GYRO:      err = ERR_GYRO;
         KIND_CLIFF:     err = ERR_CLIFF;
         KIND_CURRENT:   err = ERR_CURRENT;
         KIND_HW_VER:    err = ERR_HW_VER;
         KIND_FW_VER:    err = ERR_FW_VER;
         KIND_RAW_GYRO:  err = ERR_RAW_GYRO;
         KIND_GPIO:      err = ERR_GPIO;
         KIND_UNIQUE_ID: err = ERR_UNIQUE_ID;
         default:        err = STATUS_OK;
      endcase
      return err;
   endfunction

   function automatic logic [5:0] sfp_kind_code0(kind_type k);
      logic [5:0] code;
      unique case (k)
         KIND_BASIC:     code = CODE_TIMESTAMP;
         KIND_IR:        code = CODE_IR;
         KIND_GYRO:      code = CODE_GYRO;
         KIND_CLIFF:     code = CODE_CLIFF_SENSOR;
         KIND_CURRENT:   code = CODE_CURRENT;
         KIND_HW_VER:    code = CODE_HW_VER;
         KIND_FW_VER:    code = CODE_FW_VER;
         KIND_RAW_GYRO:  code = CODE_RAW_GYRO_FRAME;
         KIND_GPIO:      code = CODE_GPIO;
         KIND_UNIQUE_ID: code = CODE_UNIQUE_ID;
         default:        code = CODE_TIMESTAMP;
      endcase
      return code;
   endfunction

   // map a body offset to its field, byte position and last-byte flag
   function automatic locate_type sfp_locate(kind_type k, logic [3:0] offset);
      locate_type loc;
      loc = '0;
      unique case (k)
         KIND_BASIC: begin
            if (offset <= 4'd1) begin
               loc = '{hit: 1'b1, field: 4'd0, pos: offset[1:0], last: offset[0]};
            end else if (offset <= 4'd4) begin
               loc = '{hit: 1'b1, field: offset - 4'd1, pos: 2'd0, last: 1'b1};
            end else if (offset <= 4'd8) begin
               loc = '{hit: 1'b1, field: 4'd4 + ((offset - 4'd5) >> 1),
                       pos: {1'b0, ~offset[0]}, last: ~offset[0]};
            end else if (offset <= 4'd14) begin
               loc = '{hit: 1'b1, field: offset - 4'd3, pos: 2'd0, last: 1'b1};
            end
         end
         KIND_IR, KIND_HW_VER, KIND_FW_VER: begin
            if (offset < 4'd3) begin
               loc = '{hit: 1'b1, field: offset, pos: 2'd0, last: 1'b1};
            end
         end
         KIND_CURRENT: begin
            if (offset < 4'd2) begin
               loc = '{hit: 1'b1, field: offset, pos: 2'd0, last: 1'b1};
            end
         end
         KIND_GYRO: begin
            if (offset < 4'd4) begin
               loc = '{hit: 1'b1, field: offset >> 1, pos: {1'b0, offset[0]}, last: offset[0]};
            end
         end
         KIND_CLIFF: begin
            if (offset < 4'd6) begin
               loc = '{hit: 1'b1, field: offset >> 1, pos: {1'b0, offset[0]}, last: offset[0]};
            end
         end
         KIND_GPIO: begin
            if (offset < 4'd10) begin
               loc = '{hit: 1'b1, field: offset >> 1, pos: {1'b0, offset[0]}, last: offset[0]};
            end
         end
         KIND_UNIQUE_ID: begin
            if (offset < 4'd12) begin
               loc = '{hit: 1'b1, field: offset >> 2, pos: offset[1:0],
                       last: (offset[1:0] == 2'd3)};
            end
         end
         default: begin
            loc = '0;
         end
      endcase
      return loc;
   endfunction

endpackage

FILE: rtl/sfp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_front
// Request intake: accept a frame byte and tag it with its subpayload kind
// and its value divided by three before it enters the queue.
// ----------------------------------------------------------------------------
module sfp_front import sfp_pkg::*; (
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_payload,
   input  logic       queue_full,
   output qwrite_type qwrite
);

   logic [15:0] prod;

   // divide by three through the reciprocal 171/512, exact for 8-bit values
   assign prod = 16'(req_payload.frame_byte) * 16'd171;

   assign req_stall = queue_full;

   always_comb begin
      qwrite.push              = req_valid && !queue_full;
      qwrite.entry.frame_byte  = req_payload.frame_byte;
      qwrite.entry.frame_start = req_payload.frame_start;
      qwrite.entry.kind        = sfp_kind_of(req_payload.frame_byte);
      qwrite.entry.third       = prod[15:9];
   end

endmodule

FILE: rtl/sfp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_queue
// Short first-in first-out queue of classified bytes between intake and
// parser.
// ----------------------------------------------------------------------------
module sfp_queue import sfp_pkg::*; #(
   parameter int unsigned DEPTH = SFP_QUEUE_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   input  qwrite_type qwrite,
   output logic       full,
   input  logic       pop,
   output logic       nonempty,
   output entry_type  head
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   entry_type        entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full     = (count_ff == CNT_FULL);
   assign nonempty = (count_ff != '0);
   assign head     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (qwrite.push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      unique case ({qwrite.push, pop})
         2'b10:   count_in = count_ff + CNT_W'(1);
         2'b01:   count_in = count_ff - CNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (qwrite.push) begin
         entries_ff[wr_ptr_ff] <= qwrite.entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count above depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("pop from empty queue");

endmodule

FILE: rtl/sfp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfp_back
// Frame parser: checksum, subpayload walk, field assembly and the response
// register.
// ----------------------------------------------------------------------------
module sfp_back import sfp_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      q_valid,
   input  entry_type head,
   output logic      pop,
   output logic      rsp_valid,
   input  logic      rsp_stall,
   output rsp_type   rsp_payload
);

   phase_type   phase_ff, phase_in;
   logic [8:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]  xor_ff, xor_in;
   kind_type    kind_ff, kind_in;
   logic [3:0]  offset_ff, offset_in;
   logic [7:0]  skip_ff, skip_in;
   logic [31:0] acc_ff, acc_in;
   logic [6:0]  gyro_total_ff, gyro_total_in;
   logic [6:0]  gyro_cnt_ff, gyro_cnt_in;
   logic [3:0]  first_error_ff, first_error_in;
   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_data_in;

   logic        fire, active, at_end, produce;
   logic [7:0]  b, x_next;
   logic [8:0]  bl_dec, rem, six_n;
   logic        known_ff, is_raw;
   logic [4:0]  len_k, off_inc;
   locate_type  loc;
   logic [2:0]  rel;
   logic [6:0]  cnt_inc;
   logic        id_err, len_err, cnt_err, mark;
   logic [3:0]  err_code;
   logic [31:0] acc_gen;
   rsp_type     result;

   // advance one byte whenever the response register is free or drains
   assign fire = q_valid && (!rsp_valid_ff || !rsp_stall);
   assign pop  = fire;

   assign b        = head.frame_byte;
   assign x_next   = xor_ff ^ b;
   assign active   = !head.frame_start && (phase_ff != PH_IDLE) && (bytes_left_ff != 9'd0);
   assign bl_dec   = bytes_left_ff - 9'd1;
   assign at_end   = active && (bl_dec == 9'd0);
   assign rem      = bl_dec - 9'd1;
   assign known_ff = (kind_ff != KIND_UNKNOWN);
   assign is_raw   = (kind_ff == KIND_RAW_GYRO);
   assign len_k    = sfp_kind_len(kind_ff);
   assign loc      = sfp_locate(kind_ff, offset_ff);
   assign six_n    = {head.third, 2'b00} + {1'b0, head.third, 1'b0};
   assign rel      = offset_ff[2:0] - 3'd2;
   assign cnt_inc  = gyro_cnt_ff + 7'd1;
   assign off_inc  = {1'b0, offset_ff} + 5'd1;

   assign id_err  = (rem == 9'd0) && (head.kind != KIND_UNKNOWN);
   assign len_err = is_raw ? (b[0] || (rem < 9'd2))
                           : ((b != {3'b000, len_k}) || ({1'b0, b} > rem));
   assign cnt_err = (six_n > rem);
   assign mark    = active && !at_end &&
                    (((phase_ff == PH_ID) && id_err) ||
                     ((phase_ff == PH_LEN) && known_ff && len_err) ||
                     ((phase_ff == PH_BODY) && is_raw && (offset_ff == 4'd1) && cnt_err));
   assign err_code = (phase_ff == PH_ID) ? sfp_kind_err(head.kind) : sfp_kind_err(kind_ff);

   assign acc_gen = (loc.pos == 2'd0) ? 32'(b)
                                      : (acc_ff | (32'(b) << {loc.pos, 3'b000}));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         if (head.frame_start) begin
            phase_in = PH_ID;
         end else if (at_end) begin
            phase_in = PH_IDLE;
         end else if (active) begin
            unique case (phase_ff)
               PH_ID: begin
                  if (rem == 9'd0) begin
                     phase_in = id_err ? PH_DEAD : PH_ID;
                  end else begin
                     phase_in = PH_LEN;
                  end
               end
               PH_LEN: begin
                  if (!known_ff) begin
                     phase_in = (b != 8'd0) ? PH_SKIP : PH_ID;
                  end else begin
                     phase_in = len_err ? PH_DEAD : PH_BODY;
                  end
               end
               PH_SKIP: begin
                  if (skip_ff == 8'd1) begin
                     phase_in = PH_ID;
                  end
               end
               PH_BODY: begin
                  if (!known_ff) begin
                     phase_in = PH_DEAD;
                  end else if (is_raw) begin
                     if (offset_ff == 4'd1) begin
                        if (cnt_err) begin
                           phase_in = PH_DEAD;
                        end else if (head.third == 7'd0) begin
                           phase_in = PH_ID;
                        end
                     end else if ((offset_ff != 4'd0) && (rel == 3'd5) &&
                                  (cnt_inc >= gyro_total_ff)) begin
                        phase_in = PH_ID;
                     end
                  end else if (off_inc >= len_k) begin
                     phase_in = PH_ID;
                  end
               end
               PH_IDLE, PH_DEAD: begin
                  phase_in = phase_ff;
               end
               default: begin
                  phase_in = phase_ff;
               end
            endcase
         end
      end
   end

   // datapath and result
   always_comb begin
      bytes_left_in  = bytes_left_ff;
      xor_in         = xor_ff;
      kind_in        = kind_ff;
      offset_in      = offset_ff;
      skip_in        = skip_ff;
      acc_in         = acc_ff;
      gyro_total_in  = gyro_total_ff;
      gyro_cnt_in    = gyro_cnt_ff;
      first_error_in = first_error_ff;
      produce        = 1'b0;
      result         = '0;
      if (fire) begin
         if (head.frame_start) begin
            // open a new frame, dropping any frame still open
            xor_in         = b;
            bytes_left_in  = {1'b0, b} + 9'd1;
            kind_in        = KIND_BASIC;
            offset_in      = '0;
            skip_in        = '0;
            acc_in         = '0;
            gyro_total_in  = '0;
            gyro_cnt_in    = '0;
            first_error_in = STATUS_OK;
         end else if (active) begin
            xor_in        = x_next;
            bytes_left_in = bl_dec;
            if (at_end) begin
               produce             = 1'b1;
               result.is_status    = 1'b1;
               result.frame_status = (x_next != 8'd0) ? STATUS_BAD_CHECKSUM : first_error_ff;
            end else begin
               unique case (phase_ff)
                  PH_ID: begin
                     kind_in = head.kind;
                  end
                  PH_LEN: begin
                     offset_in = '0;
                     if (!known_ff) begin
                        skip_in = b;
                     end
                  end
                  PH_SKIP: begin
                     skip_in = skip_ff - 8'd1;
                  end
                  PH_BODY: begin
                     if (known_ff && is_raw) begin
                        if (offset_ff == 4'd0) begin
                           offset_in          = 4'd1;
                           produce            = 1'b1;
                           result.field_code  = CODE_RAW_GYRO_FRAME;
                           result.field_value = 32'(b);
                        end else if (offset_ff == 4'd1) begin
                           gyro_total_in = head.third;
                           gyro_cnt_in   = '0;
                           if (!cnt_err && (head.third != 7'd0)) begin
                              offset_in = 4'd2;
                           end
                        end else begin
                           acc_in = rel[0] ? (acc_ff | (32'(b) << 8)) : 32'(b);
                           if (rel == 3'd5) begin
                              gyro_cnt_in = cnt_inc;
                              offset_in   = 4'd2;
                           end else begin
                              offset_in = off_inc[3:0];
                           end
                           if (rel[0]) begin
                              produce             = 1'b1;
                              result.field_code   = CODE_RAW_GYRO_X + 6'(rel[2:1]);
                              result.sample_index = gyro_cnt_ff[5:0];
                              result.field_value  = acc_ff | (32'(b) << 8);
                           end
                        end
                     end else if (known_ff) begin
                        offset_in = off_inc[3:0];
                        if (loc.hit) begin
                           acc_in = acc_gen;
                           if (loc.last) begin
                              produce            = 1'b1;
                              result.field_code  = sfp_kind_code0(kind_ff) + 6'(loc.field);
                              result.field_value = acc_gen;
                              // bumper, wheel drop and cliff groups keep three bits
                              if ((result.field_code >= CODE_BUMPER) &&
                                  (result.field_code <= CODE_CLIFF_BITS)) begin
                                 result.field_value = {29'd0, acc_gen[2:0] & FLAG_MASK};
                              end
                           end
                        end
                     end
                  end
                  PH_IDLE, PH_DEAD: begin
                     produce = 1'b0;
                  end
                  default: begin
                     produce = 1'b0;
                  end
               endcase
               if (mark && (first_error_ff == STATUS_OK)) begin
                  first_error_in = err_code;
               end
            end
         end
      end
   end

   assign rsp_valid_in = fire ? produce : (rsp_valid_ff && rsp_stall);
   assign rsp_data_in  = (fire && produce) ? result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_IDLE;
         bytes_left_ff  <= '0;
         xor_ff         <= '0;
         kind_ff        <= KIND_BASIC;
         offset_ff      <= '0;
         skip_ff        <= '0;
         gyro_total_ff  <= '0;
         gyro_cnt_ff    <= '0;
         first_error_ff <= STATUS_OK;
         rsp_valid_ff   <= 1'b0;
      end else begin
         phase_ff       <= phase_in;
         bytes_left_ff  <= bytes_left_in;
         xor_ff         <= xor_in;
         kind_ff        <= kind_in;
         offset_ff      <= offset_in;
         skip_ff        <= skip_in;
         gyro_total_ff  <= gyro_total_in;
         gyro_cnt_ff    <= gyro_cnt_in;
         first_error_ff <= first_error_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff      <= acc_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   a_idle_no_bytes: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> (bytes_left_ff == 9'd0))
      else $error("idle phase with bytes still due");

   a_raw_offset: assert property (@(posedge clock) disable iff (reset)
      ((phase_ff == PH_BODY) && (kind_ff == KIND_RAW_GYRO)) |-> (offset_ff <= 4'd7))
      else $error("raw gyro offset out of range");

   a_status_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.is_status) |->
         ((rsp_data_ff.field_code == 6'd0) && (rsp_data_ff.field_value == 32'd0) &&
          (rsp_data_ff.sample_index == 6'd0)))
      else $error("status result carries field data");

   a_start_opens: assert property (@(posedge clock) disable iff (reset)
      (fire && head.frame_start) |=>
         ((phase_ff == PH_ID) && (first_error_ff == STATUS_OK)))
      else $error("frame start did not open a clean frame");

endmodule

FILE: rtl/sensor_feedback_frame_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sensor_feedback_frame_parser
// Byte-stream parser for sensor feedback frames with XOR checksum.
// ----------------------------------------------------------------------------
// The block takes one frame byte per request and sustains one byte per clock
// cycle while rsp_stall is low; each byte costs exactly one step of the
// parser in sfp_back, and its result is registered in the response register
// once the byte leaves the byte queue. Mark the payload length byte with
// frame_start; the length, the payload and the trailing checksum byte are
// XORed together. The payload is walked as id/length subpayloads: each
// known little-endian sensor field (8 to 32 bits) comes out as one response
// when its last byte arrives, raw gyro samples carry their sample number,
// and unknown ids are skipped by their length. The checksum byte yields one
// status response: a bad checksum reports 1, otherwise the first length or
// overrun error of the frame, otherwise 0. Once a structure error is seen no
// further field of the frame is emitted. Bytes outside a frame are dropped
// silently, and a new start byte abandons an open frame without a status.
// req_stall rises only when the byte queue (QUEUE_DEPTH entries) is full
// because rsp_stall has held the response register.
// ----------------------------------------------------------------------------
module sensor_feedback_frame_parser import sfp_pkg::*; #(
   parameter int unsigned QUEUE_DEPTH = SFP_QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   qwrite_type qwrite;
   logic       queue_full;
   logic       q_valid;
   logic       q_pop;
   entry_type  q_head;

   // classify each byte on the way in
   sfp_front u_front (
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .queue_full  (queue_full),
      .qwrite      (qwrite)
   );

   // decouple intake from parser stalls
   sfp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .qwrite   (qwrite),
      .full     (queue_full),
      .pop      (q_pop),
      .nonempty (q_valid),
      .head     (q_head)
   );

   // parse one byte per cycle, while rsp_stall is low, into the response register
   sfp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .head        (q_head),
      .pop         (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
